FILE: sv/hmpc_pkg.sv
// Package for the heater mode and reflow profile controller.
// Holds the command, mode, sequencer and arithmetic codes and the point reset table.
// No dependencies.
`default_nettype none

package hmpc_pkg;

  // Widths fixed by the field definitions.
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned VALUE_W = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PTIME_W = 16;
  localparam int unsigned TEMP_W  = 8;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Storage for the profile points and the arithmetic widths.
  localparam int unsigned NPTS_MAX = 4;
  localparam int unsigned PIDX_W   = 2;
  localparam int unsigned MS_W     = 26;   // 65535 s in ms fits in 26 bits
  localparam int unsigned PROD_W   = TEMP_W + MS_W;
  localparam int unsigned ACC_W    = PROD_W + 1;
  localparam int unsigned DVS_W    = MS_W + 1;
  localparam int unsigned QUO_W    = 8;
  localparam int unsigned QK_W     = 3;

  localparam logic [MS_W-1:0]    MS_PER_S     = 26'd1000;
  localparam logic [VALUE_W-1:0] MAX_SET_TEMP = 8'd240;
  localparam logic [VALUE_W-1:0] MAX_SET_PCT  = 8'd100;

  localparam logic [PTIME_W-1:0] PT_TIME_RST [NPTS_MAX] = '{16'd0, 16'd60, 16'd120, 16'd165};
  localparam logic [TEMP_W-1:0]  PT_TEMP_RST [NPTS_MAX] = '{8'd30, 8'd150, 8'd150, 8'd240};

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK     = 3'd0,
    KIND_DISABLE  = 3'd1,
    KIND_START    = 3'd2,
    KIND_SET_TEMP = 3'd3,
    KIND_SET_PWM  = 3'd4
  } hmpc_kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PWM   = 2'd1,
    MODE_TEMP  = 2'd2,
    MODE_CURVE = 2'd3
  } hmpc_mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MUL0,
    S_MUL1,
    S_DINIT,
    S_DIV,
    S_EMIT
  } hmpc_state_e;

  typedef enum logic [2:0] {
    ARITH_HOLD,
    ARITH_MUL,
    ARITH_MAC_ADD,
    ARITH_MAC_SUB,
    ARITH_DIV_INIT,
    ARITH_DIV_STEP
  } hmpc_arith_op_e;

  typedef struct packed {
    hmpc_arith_op_e    op;
    logic [TEMP_W-1:0] mul_a;
    logic [MS_W-1:0]   mul_b;
    logic [QK_W-1:0]   k;
  } hmpc_arith_cmd_t;

  // Seconds to milliseconds for a profile point time.
  function automatic logic [MS_W-1:0] sec_to_ms(input logic [PTIME_W-1:0] s);
    logic [MS_W-1:0] r;
    r = MS_W'(s) * MS_PER_S;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/hmpc_if.sv
// Valid/ready channel interfaces for the command/tick words and the result words.
// Depends on hmpc_pkg for the field widths.
`default_nettype none

interface hmpc_in_if;
  import hmpc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [VALUE_W-1:0]   value;
  logic [TIME_W-1:0]    now_ms;

  modport source (output valid, kind, value, now_ms, input ready);
  modport sink   (input valid, kind, value, now_ms, output ready);
endinterface

interface hmpc_out_if;
  import hmpc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 relay_on;
  logic [LEVEL_W-1:0]   pwm_level;
  logic [PCT_W-1:0]     duty_pct;
  logic [TEMP_W-1:0]    target_temp_c;
  logic [1:0]           mode;
  logic [TIME_W-1:0]    curve_age_ms;
  logic [TIME_W-1:0]    curve_left_ms;
  logic                 curve_done;

  modport source (output valid, relay_on, pwm_level, duty_pct, target_temp_c, mode,
                  curve_age_ms, curve_left_ms, curve_done, input ready);
  modport sink   (input valid, relay_on, pwm_level, duty_pct, target_temp_c, mode,
                  curve_age_ms, curve_left_ms, curve_done, output ready);
endinterface

`default_nettype wire

FILE: sv/hmpc_arith.sv
// Shared arithmetic unit: one 8x26 multiplier and one wide adder/subtractor.
// Performs multiply-accumulate and restoring division steps. Depends on hmpc_pkg.
`default_nettype none

module hmpc_arith
  import hmpc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire hmpc_arith_cmd_t  cmd_i,
  output logic [QUO_W-1:0]      quo_o
);

  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [QUO_W-1:0]  quo_q, quo_d;

  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  lhs, rhs;
  logic              sub;
  logic [ACC_W:0]    sum;

  assign prod = PROD_W'(cmd_i.mul_a) * PROD_W'(cmd_i.mul_b);

  // The one adder; a carry out on subtraction means no borrow.
  assign sum = {1'b0, lhs} + {1'b0, (sub ? ~rhs : rhs)} + {{ACC_W{1'b0}}, sub};

  always_comb begin
    lhs   = acc_q;
    rhs   = {1'b0, prod};
    sub   = 1'b0;
    acc_d = acc_q;
    dvs_d = dvs_q;
    quo_d = quo_q;
    case (cmd_i.op)
      ARITH_MUL: begin
        lhs   = '0;
        acc_d = sum[ACC_W-1:0];
      end
      ARITH_MAC_ADD: begin
        acc_d = sum[ACC_W-1:0];
      end
      ARITH_MAC_SUB: begin
        sub   = 1'b1;
        acc_d = sum[ACC_W-1:0];
      end
      ARITH_DIV_INIT: begin
        // Rounded quotient: (2*num + den) / (2*den).
        lhs   = {acc_q[ACC_W-2:0], 1'b0};
        rhs   = ACC_W'(cmd_i.mul_b);
        acc_d = sum[ACC_W-1:0];
        dvs_d = {cmd_i.mul_b, 1'b0};
        quo_d = '0;
      end
      ARITH_DIV_STEP: begin
        rhs = ACC_W'(dvs_q) << cmd_i.k;
        sub = 1'b1;
        if (sum[ACC_W]) begin
          acc_d          = sum[ACC_W-1:0];
          quo_d[cmd_i.k] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

`default_nettype wire

FILE: sv/heater_mode_profile_controller.sv
// Top level of the heater mode controller with a piecewise linear reflow profile.
// Depends on hmpc_pkg, hmpc_if (channel interfaces) and hmpc_arith (shared arithmetic unit).
`default_nettype none

// The controller holds one of four modes (idle, fixed PWM, temperature hold, profile
// curve) and answers every tick word with one result word; command words produce no
// result. A command is applied when it is taken and leaves the sequencer idle. A tick
// outside curve mode goes from the idle state through the emit state into the output
// register. A tick in curve mode walks the profile points one per cycle (up to
// NUM_POINTS points) and, when it lands between two points, runs the shared
// multiplier twice and then eight restoring division steps on the shared adder. The
// input is ready only while the sequencer is idle. The result sits in an output
// register, so the next word is taken while a result still waits to be read; a new
// result waits in the emit state until the previous one has been taken. The
// interpolated target is rounded half away from zero with exact integer arithmetic.
// Profile points are written through the configuration port (even index: time in
// seconds, odd index: temperature) and should only be changed while the block is idle.
module heater_mode_profile_controller
  import hmpc_pkg::*;
#(
  parameter int unsigned NUM_POINTS = 4,
  parameter int unsigned PWM_SCALE  = 500
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  hmpc_in_if.sink                    in_i,
  hmpc_out_if.source                 out_o
);

  localparam logic [PIDX_W-1:0] LastIdx = PIDX_W'(NUM_POINTS - 1);
  localparam logic [QK_W-1:0]   TopK    = QK_W'(QUO_W - 1);

  // Profile point registers.
  logic [PTIME_W-1:0] pt_time_q [NPTS_MAX];
  logic [TEMP_W-1:0]  pt_temp_q [NPTS_MAX];

  // Mode state.
  hmpc_mode_e         mode_q;
  logic [PCT_W-1:0]   pct_q;
  logic [TEMP_W-1:0]  target_q;
  logic [TIME_W-1:0]  start_q;

  // Sequencer.
  hmpc_state_e        state_q, state_d;
  logic [PIDX_W-1:0]  idx_q;
  logic [QK_W-1:0]    k_q;
  hmpc_arith_cmd_t    arith_cmd;
  logic [QUO_W-1:0]   quo;

  // Per-tick working values.
  logic [TIME_W-1:0]  t_q;
  logic [MS_W-1:0]    xprev_q;
  logic [MS_W-1:0]    den_q;
  logic [MS_W-1:0]    dt_q;
  logic [TEMP_W-1:0]  y0_q, y1_q;
  hmpc_mode_e         res_mode_q;
  logic [TEMP_W-1:0]  res_target_q;
  logic [TIME_W-1:0]  res_remaining_q;
  logic               res_done_q;
  logic               from_div_q;

  // Output word register.
  logic               out_valid_q;
  logic               o_relay_q;
  logic [LEVEL_W-1:0] o_level_q;
  logic [PCT_W-1:0]   o_pct_q;
  logic [TEMP_W-1:0]  o_target_q;
  logic [1:0]         o_mode_q;
  logic [TIME_W-1:0]  o_elapsed_q;
  logic [TIME_W-1:0]  o_remaining_q;
  logic               o_done_q;

  logic               in_fire;
  logic               emit_fire;
  logic [MS_W-1:0]    xi;
  logic [MS_W-1:0]    end_ms;
  logic               before_xi;
  logic [PCT_W-1:0]   emit_pct;
  logic [TEMP_W-1:0]  emit_target;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign emit_fire  = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);

  assign xi        = sec_to_ms(pt_time_q[idx_q]);
  assign end_ms    = sec_to_ms(pt_time_q[LastIdx]);
  assign before_xi = t_q < TIME_W'(xi);

  // A finished curve drives no heat; otherwise the stored percent applies.
  assign emit_pct    = res_done_q ? '0 : pct_q;
  assign emit_target = from_div_q ? quo : res_target_q;

  hmpc_arith u_arith (
    .clk_i (clk_i),
    .cmd_i (arith_cmd),
    .quo_o (quo)
  );

  // Next state and the command for the shared unit.
  always_comb begin
    state_d         = state_q;
    arith_cmd.op    = ARITH_HOLD;
    arith_cmd.mul_a = y0_q;
    arith_cmd.mul_b = den_q;
    arith_cmd.k     = k_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && (in_i.kind == KIND_TICK)) begin
          state_d = (mode_q == MODE_CURVE) ? S_SEARCH : S_EMIT;
        end
      end
      S_SEARCH: begin
        if (before_xi) begin
          state_d = (idx_q == '0) ? S_EMIT : S_MUL0;
        end else if (idx_q == LastIdx) begin
          state_d = S_EMIT;
        end
      end
      S_MUL0: begin
        arith_cmd.op = ARITH_MUL;
        state_d      = S_MUL1;
      end
      S_MUL1: begin
        arith_cmd.mul_b = dt_q;
        if (y1_q >= y0_q) begin
          arith_cmd.op    = ARITH_MAC_ADD;
          arith_cmd.mul_a = y1_q - y0_q;
        end else begin
          arith_cmd.op    = ARITH_MAC_SUB;
          arith_cmd.mul_a = y0_q - y1_q;
        end
        state_d = S_DINIT;
      end
      S_DINIT: begin
        arith_cmd.op = ARITH_DIV_INIT;
        state_d      = S_DIV;
      end
      S_DIV: begin
        arith_cmd.op = ARITH_DIV_STEP;
        if (k_q == '0) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_time_q <= PT_TIME_RST;
      pt_temp_q <= PT_TEMP_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i[0]) begin
        pt_temp_q[cfg_idx_i[CFG_IDX_W-1:1]] <= cfg_data_i[TEMP_W-1:0];
      end else begin
        pt_time_q[cfg_idx_i[CFG_IDX_W-1:1]] <= cfg_data_i[PTIME_W-1:0];
      end
    end
  end

  // Mode state: commands are applied on acceptance, and a curve tick updates the
  // target (or ends the curve) when its result is emitted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pct_q    <= '0;
      target_q <= '0;
      start_q  <= '0;
    end else if (in_fire) begin
      case (in_i.kind)
        KIND_DISABLE: begin
          mode_q   <= MODE_IDLE;
          pct_q    <= '0;
          target_q <= '0;
        end
        KIND_START: begin
          // A running curve is not restarted.
          if (mode_q != MODE_CURVE) begin
            mode_q   <= MODE_CURVE;
            pct_q    <= '0;
            target_q <= '0;
            start_q  <= in_i.now_ms;
          end
        end
        KIND_SET_TEMP: begin
          if (in_i.value <= MAX_SET_TEMP) begin
            mode_q   <= MODE_TEMP;
            pct_q    <= '0;
            target_q <= in_i.value;
          end
        end
        KIND_SET_PWM: begin
          if (in_i.value <= MAX_SET_PCT) begin
            mode_q   <= MODE_PWM;
            pct_q    <= in_i.value[PCT_W-1:0];
            target_q <= '0;
          end
        end
        default: begin
        end
      endcase
    end else if (emit_fire && (res_mode_q == MODE_CURVE)) begin
      if (res_done_q) begin
        mode_q   <= MODE_IDLE;
        pct_q    <= '0;
        target_q <= '0;
      end else begin
        target_q <= emit_target;
      end
    end
  end

  // Working registers of the tick sequence.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_mode_q      <= mode_q;
          res_target_q    <= target_q;
          res_remaining_q <= '0;
          res_done_q      <= 1'b0;
          from_div_q      <= 1'b0;
          idx_q           <= '0;
          xprev_q         <= '0;
          t_q             <= (mode_q == MODE_CURVE) ? (in_i.now_ms - start_q) : '0;
        end
      end
      S_SEARCH: begin
        res_remaining_q <= (t_q < TIME_W'(end_ms)) ? (TIME_W'(end_ms) - t_q) : '0;
        if (before_xi) begin
          // Before the first point the first temperature holds.
          res_target_q <= pt_temp_q[idx_q];
          den_q        <= xi - xprev_q;
          dt_q         <= t_q[MS_W-1:0] - xprev_q;
          y1_q         <= pt_temp_q[idx_q];
          y0_q         <= pt_temp_q[idx_q - PIDX_W'(1)];
        end else if (idx_q == LastIdx) begin
          res_target_q <= '0;
          res_done_q   <= 1'b1;
        end else begin
          idx_q   <= idx_q + PIDX_W'(1);
          xprev_q <= xi;
        end
      end
      S_DINIT: begin
        k_q <= TopK;
      end
      S_DIV: begin
        k_q <= k_q - QK_W'(1);
        if (k_q == '0) begin
          from_div_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      o_relay_q     <= (emit_pct != '0);
      o_level_q     <= LEVEL_W'(32'(emit_pct) * PWM_SCALE);
      o_pct_q       <= emit_pct;
      o_target_q    <= emit_target;
      o_mode_q      <= res_mode_q;
      o_elapsed_q   <= t_q;
      o_remaining_q <= res_remaining_q;
      o_done_q      <= res_done_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.relay_on      = o_relay_q;
  assign out_o.pwm_level     = o_level_q;
  assign out_o.duty_pct      = o_pct_q;
  assign out_o.target_temp_c = o_target_q;
  assign out_o.mode          = o_mode_q;
  assign out_o.curve_age_ms  = o_elapsed_q;
  assign out_o.curve_left_ms = o_remaining_q;
  assign out_o.curve_done    = o_done_q;

`ifndef ASSERT_OFF
  a_load_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_EMIT)
    else $error("result word appeared without an emit");

  a_done_in_curve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_done_q) |-> (o_mode_q == MODE_CURVE) && (o_target_q == '0)
                                  && (o_pct_q == '0))
    else $error("curve end reported outside curve mode or with a target");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && res_done_q) |=> (mode_q == MODE_IDLE) && (target_q == '0))
    else $error("mode did not return to idle after the curve ended");

  a_timing_only_in_curve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (o_mode_q != MODE_CURVE)) |-> (o_elapsed_q == '0)
                                                   && (o_remaining_q == '0))
    else $error("curve timing reported outside curve mode");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DIV) || (state_q == S_SEARCH)) |-> !in_i.ready)
    else $error("input taken while a tick is in progress");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/heater_mode_profile_controller_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for heater_mode_profile_controller: command and tick words go in
// with random gaps, status words come out under random back-pressure and are checked
// against a behavioral model of the controller. Needs hmpc_pkg, hmpc_if and the RTL.

module heater_mode_profile_controller_tb;
  import hmpc_pkg::*;

  localparam int unsigned NUM_POINTS    = 4;
  localparam int unsigned PWM_SCALE     = 500;
  localparam int unsigned MS_PER_SEC    = 1000;
  localparam int unsigned PCT_LIMIT     = 100;
  localparam int unsigned TEMP_LIMIT    = 240;
  localparam int unsigned CLK_HALF      = 6;
  localparam int unsigned RESET_CYCLES  = 5;
  // Wait before touching the profile registers so that a trailing command is surely finished.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_IDLE      = 19;
  localparam int unsigned ITEM_GOAL     = 1500;
  localparam int unsigned NUM_PROFILES  = 7;
  localparam int unsigned CYCLE_LIMIT   = 800000;
  localparam int unsigned MAX_PRINTS    = 200;
  localparam int unsigned NUM_DIRECTED  = 27;

  // Kinds the block must drop without a status word.
  localparam logic [KIND_W-1:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_LAST  = 3'd7;

  // Profile register map: time of point p at 2p, its temperature at 2p + 1.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P0_TIME, REG_P0_TEMP, REG_P1_TIME, REG_P1_TEMP,
    REG_P2_TIME, REG_P2_TEMP, REG_P3_TIME, REG_P3_TEMP
  } profile_reg_e;

  localparam profile_reg_e TIME_REG [NPTS_MAX] = '{REG_P0_TIME, REG_P1_TIME, REG_P2_TIME,
                                                    REG_P3_TIME};
  localparam profile_reg_e TEMP_REG [NPTS_MAX] = '{REG_P0_TEMP, REG_P1_TEMP, REG_P2_TEMP,
                                                    REG_P3_TEMP};

  // One status word as the block reports it on a tick.
  typedef struct packed {
    logic               relay_on;
    logic [LEVEL_W-1:0] pwm_level;
    logic [PCT_W-1:0]   duty_pct;
    logic [TEMP_W-1:0]  target_c;
    hmpc_mode_e         mode;
    logic [TIME_W-1:0]  elapsed_ms;
    logic [TIME_W-1:0]  remaining_ms;
    logic               done;
  } heater_status_t;

  // One row of the directed script. When typed is set, the status word is taken from
  // the row itself instead of from the model.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [TIME_W-1:0]  now_ms;
    logic               typed;
    heater_status_t     status;
  } script_row_t;

  localparam heater_status_t STATUS_OFF = '0;
  localparam heater_status_t STATUS_PWM_FULL =
    '{1'b1, 16'd50000, 7'd100, 8'd0, MODE_PWM, 32'd0, 32'd0, 1'b0};
  localparam heater_status_t STATUS_HOLD_240 =
    '{1'b0, 16'd0, 7'd0, 8'd240, MODE_TEMP, 32'd0, 32'd0, 1'b0};

  // The directed part runs on the reset profile: (0 s, 30 C), (60 s, 150 C),
  // (120 s, 150 C), (165 s, 240 C). It walks every command, the limits of the set
  // commands, a curve from its first tick to its end, a restart that must be ignored,
  // an unknown kind, a curve start right before the millisecond counter wraps and a
  // PWM command that cuts a running curve short.
  localparam script_row_t DIRECTED [NUM_DIRECTED] = '{
    '{KIND_TICK,       8'd0,   32'd0,      1'b1, STATUS_OFF},
    '{KIND_SET_PWM,    8'd100, 32'd0,      1'b0, STATUS_OFF},
    '{KIND_TICK,       8'd0,   32'd10,     1'b1, STATUS_PWM_FULL},
    '{KIND_SET_PWM,    8'd101, 32'd20,     1'b0, STATUS_OFF},
    '{KIND_TICK,       8'd0,   32'd30,     1'b1, STATUS_PWM_FULL},
    '{KIND_SET_PWM,    8'd0,   32'd40,     1'b0, STATUS_OFF},
    '{KIND_TICK,       8'd0,   32'd50,     1'b1,
      '{1'b0, 16'd0, 7'd0, 8'd0, MODE_PWM, 32'd0, 32'd0, 1'b0}},
    '{KIND_SET_TEMP,   8'd240, 32'd60,     1'b0, STATUS_OFF},
    '{KIND_TICK,       8'd0,   32'd70,     1'b1, STATUS_HOLD_240},
    '{KIND_SET_TEMP,   8'd241, 32'd80,     1'b0, STATUS_OFF},
    '{KIND_TICK,       8'd255, 32'd90,     1'b1, STATUS_HOLD_240},
    '{KIND_SET_TEMP,   8'd0,   32'd100,    1'b0, STATUS_OFF},
    '{KIND_TICK,       8'd0,   32'd110,    1'b1,
      '{1'b0, 16'd0, 7'd0, 8'd0, MODE_TEMP, 32'd0, 32'd0, 1'b0}},
    '{KIND_DISABLE,    8'd0,   32'd120,    1'b0, STATUS_OFF},
    '{KIND_TICK,       8'd0,   32'd130,    1'b1, STATUS_OFF},
    '{KIND_START,      8'd0,   32'd1000,   1'b0, STATUS_OFF},
    '{KIND_TICK,       8'd0,   32'd1000,   1'b1,
      '{1'b0, 16'd0, 7'd0, 8'd30, MODE_CURVE, 32'd0, 32'd165000, 1'b0}},
    '{KIND_START,      8'd0,   32'd5000,   1'b0, STATUS_OFF},
    '{KIND_TICK,       8'd0,   32'd31000,  1'b0, STATUS_OFF},
    '{KIND_TICK,       8'd0,   32'd166000, 1'b1,
      '{1'b0, 16'd0, 7'd0, 8'd0, MODE_CURVE, 32'd165000, 32'd0, 1'b1}},
    '{KIND_TICK,       8'd0,   32'd166000, 1'b1, STATUS_OFF},
    '{KIND_RSVD_LAST,  8'd255, 32'hFFFFFFFF, 1'b0, STATUS_OFF},
    '{KIND_START,      8'd0,   32'hFFFFFFFF, 1'b0, STATUS_OFF},
    '{KIND_TICK,       8'd0,   32'h00000FFF, 1'b0, STATUS_OFF},
    '{KIND_SET_PWM,    8'd55,  32'h00001000, 1'b0, STATUS_OFF},
    '{KIND_TICK,       8'd0,   32'h00001100, 1'b0, STATUS_OFF},
    '{KIND_DISABLE,    8'd0,   32'h00001200, 1'b0, STATUS_OFF}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  hmpc_in_if  in_ch ();
  hmpc_out_if out_ch ();

  heater_mode_profile_controller #(
    .NUM_POINTS(NUM_POINTS),
    .PWM_SCALE (PWM_SCALE)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  // Model state: the profile as written and the controller registers.
  logic [PTIME_W-1:0] pt_sec [NPTS_MAX] = '{16'd0, 16'd60, 16'd120, 16'd165};
  logic [TEMP_W-1:0]  pt_deg [NPTS_MAX] = '{8'd30, 8'd150, 8'd150, 8'd240};
  hmpc_mode_e         mode_q  = MODE_IDLE;
  logic [PCT_W-1:0]   pct_q   = '0;
  logic [TEMP_W-1:0]  tgt_q   = '0;
  logic [TIME_W-1:0]  start_q = '0;

  heater_status_t status_due [$];
  int unsigned    errors      = 0;
  int unsigned    words_sent  = 0;
  int unsigned    status_seen = 0;
  int unsigned    cycle_count = 0;
  bit             tx_burst    = 1'b0;
  bit             rx_burst    = 1'b0;

  always begin
    clk_i = 1'b0;
    #(CLK_HALF);
    clk_i = 1'b1;
    #(CLK_HALF);
  end

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] status word %0d: %s", $time, status_seen, msg);
  endtask

  // Applies one accepted word to the model. A tick yields the status word it must
  // produce; commands only move the state.
  task automatic advance_controller(input logic [KIND_W-1:0] kind,
                                    input logic [VALUE_W-1:0] value,
                                    input logic [TIME_W-1:0] now_ms,
                                    output bit emits, output heater_status_t st);
    logic [TIME_W-1:0] end_ms;
    logic [TEMP_W-1:0] setpoint;
    longint unsigned   hi_ms, lo_ms, width, dt, y0, y1, num;
    bit                found;
    emits = 1'b0;
    st    = STATUS_OFF;
    case (kind)
      KIND_DISABLE: begin
        mode_q = MODE_IDLE;
        pct_q  = '0;
        tgt_q  = '0;
      end
      KIND_START: begin
        // A running curve keeps its original start time.
        if (mode_q != MODE_CURVE) begin
          mode_q  = MODE_CURVE;
          pct_q   = '0;
          tgt_q   = '0;
          start_q = now_ms;
        end
      end
      KIND_SET_TEMP: begin
        if (value <= TEMP_LIMIT) begin
          mode_q = MODE_TEMP;
          pct_q  = '0;
          tgt_q  = value;
        end
      end
      KIND_SET_PWM: begin
        if (value <= PCT_LIMIT) begin
          mode_q = MODE_PWM;
          pct_q  = PCT_W'(value);
          tgt_q  = '0;
        end
      end
      KIND_TICK: begin
        emits       = 1'b1;
        st.mode     = mode_q;
        st.target_c = tgt_q;
        if (mode_q == MODE_CURVE) begin
          end_ms          = TIME_W'(pt_sec[NUM_POINTS-1]) * MS_PER_SEC;
          st.elapsed_ms   = now_ms - start_q;
          st.remaining_ms = (st.elapsed_ms < end_ms) ? end_ms - st.elapsed_ms : '0;
          // The first point whose time lies beyond the elapsed time picks the segment;
          // before the first point the first temperature is held. Rounding is half
          // away from zero, done on exact integers.
          found    = 1'b0;
          setpoint = '0;
          for (int i = 0; i < NUM_POINTS && !found; i++) begin
            hi_ms = 64'(pt_sec[i]) * MS_PER_SEC;
            if (64'(st.elapsed_ms) < hi_ms) begin
              found = 1'b1;
              if (i == 0) begin
                setpoint = pt_deg[0];
              end else begin
                lo_ms = 64'(pt_sec[i-1]) * MS_PER_SEC;
                width = hi_ms - lo_ms;
                dt    = 64'(st.elapsed_ms) - lo_ms;
                y0    = 64'(pt_deg[i-1]);
                y1    = 64'(pt_deg[i]);
                if (y1 >= y0) num = y0 * width + (y1 - y0) * dt;
                else          num = y0 * width - (y0 - y1) * dt;
                setpoint = TEMP_W'((2 * num + width) / (2 * width));
              end
            end
          end
          if (found) begin
            st.target_c = setpoint;
            tgt_q       = setpoint;
          end else begin
            // Past the last point: report the end once and fall back to idle.
            st.target_c = '0;
            st.done     = 1'b1;
            mode_q      = MODE_IDLE;
            pct_q       = '0;
            tgt_q       = '0;
          end
        end
        st.duty_pct  = st.done ? '0 : pct_q;
        st.relay_on  = (st.duty_pct != 0);
        st.pwm_level = LEVEL_W'(st.duty_pct * PWM_SCALE);
      end
      default: begin
      end
    endcase
  endtask

  // Offers one word after a random gap, holds it until the block takes it and then
  // books the status word it is to produce. Valid stays high on return so that a
  // following word with no gap goes out back to back.
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                           input logic [TIME_W-1:0] now_ms, input bit typed,
                           input heater_status_t typed_status);
    int unsigned    gap;
    bit             emits;
    heater_status_t st;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
    @(negedge clk_i);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid  = 1'b1;
    in_ch.kind   = kind;
    in_ch.value  = value;
    in_ch.now_ms = now_ms;
    do @(posedge clk_i); while (!in_ch.ready);
    advance_controller(kind, value, now_ms, emits, st);
    if (emits) status_due.push_back(typed ? typed_status : st);
    if (kind <= KIND_SET_PWM) words_sent++;
  endtask

  // Stops offering words and waits until every booked status word has been seen.
  task automatic wait_for_results(input int unsigned settle);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input profile_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
  endtask

  // Set values are biased toward the accept and reject limits.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return VALUE_W'(PCT_LIMIT);
      1:       return VALUE_W'(PCT_LIMIT + 1);
      2:       return VALUE_W'(TEMP_LIMIT);
      3:       return VALUE_W'(TEMP_LIMIT + 1);
      default: return VALUE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Status side: draws a stall before each word, then waits for it and compares it
  // field by field with the oldest booked word.
  initial begin : status_sink
    int unsigned    stall;
    heater_status_t want;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 47) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
      @(negedge clk_i);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      if (status_due.size() == 0) begin
        flag_mismatch("arrived with no status word pending");
      end else begin
        want = status_due.pop_front();
        if (out_ch.relay_on !== want.relay_on)
          flag_mismatch($sformatf("relay_on %0d, want %0d", out_ch.relay_on, want.relay_on));
        if (out_ch.pwm_level !== want.pwm_level)
          flag_mismatch($sformatf("pwm_level %0d, want %0d", out_ch.pwm_level,
                                  want.pwm_level));
        if (out_ch.duty_pct !== want.duty_pct)
          flag_mismatch($sformatf("duty_pct %0d, want %0d", out_ch.duty_pct,
                                  want.duty_pct));
        if (out_ch.target_temp_c !== want.target_c)
          flag_mismatch($sformatf("target_temp_c %0d, want %0d", out_ch.target_temp_c,
                                  want.target_c));
        if (out_ch.mode !== want.mode)
          flag_mismatch($sformatf("mode %0d, want %0d", out_ch.mode, want.mode));
        if (out_ch.curve_age_ms !== want.elapsed_ms)
          flag_mismatch($sformatf("curve_age_ms %0d, want %0d", out_ch.curve_age_ms,
                                  want.elapsed_ms));
        if (out_ch.curve_left_ms !== want.remaining_ms)
          flag_mismatch($sformatf("curve_left_ms %0d, want %0d",
                                  out_ch.curve_left_ms, want.remaining_ms));
        if (out_ch.curve_done !== want.done)
          flag_mismatch($sformatf("curve_done %0d, want %0d", out_ch.curve_done, want.done));
      end
      status_seen++;
    end
  end

  // Hard stop in case the block hangs or drops a status word.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [PTIME_W-1:0] secs [NPTS_MAX];
    logic [TEMP_W-1:0]  degs [NPTS_MAX];
    logic [TIME_W-1:0]  origin, offset, span;
    int unsigned        quota, ticks, step_max;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = '0;
    in_ch.value  = '0;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < NUM_DIRECTED; r++)
      send_word(DIRECTED[r].kind, DIRECTED[r].value, DIRECTED[r].now_ms, DIRECTED[r].typed,
                DIRECTED[r].status);

    // Random part: one profile per phase, the register writes only once the block has
    // gone quiet. The first phases cover the corners (every point at the largest time,
    // every point at zero, times out of order); the rest are ordered curves, one with
    // a nonzero first time so the hold before the first point is reached, one packed
    // against the top of the time range.
    for (int p = 1; p <= NUM_PROFILES; p++) begin
      wait_for_results(SETTLE_CYCLES);
      case (p)
        1: begin
          for (int i = 0; i < NPTS_MAX; i++) begin
            secs[i] = '1;
            degs[i] = (i % 2 == 0) ? '1 : '0;
          end
        end
        2: begin
          for (int i = 0; i < NPTS_MAX; i++) begin
            secs[i] = '0;
            degs[i] = TEMP_W'($urandom_range(0, 255));
          end
        end
        3: begin
          for (int i = 0; i < NPTS_MAX; i++) begin
            secs[i] = PTIME_W'($urandom_range(0, 120));
            degs[i] = TEMP_W'($urandom_range(0, 255));
          end
        end
        4: begin
          secs[0] = PTIME_W'($urandom_range(1, 20));
          for (int i = 1; i < NPTS_MAX; i++)
            secs[i] = PTIME_W'(secs[i-1] + $urandom_range(1, 40));
          for (int i = 0; i < NPTS_MAX; i++) degs[i] = TEMP_W'($urandom_range(0, 255));
        end
        5: begin
          secs[0] = PTIME_W'($urandom_range(65500, 65505));
          for (int i = 1; i < NPTS_MAX; i++)
            secs[i] = PTIME_W'(secs[i-1] + $urandom_range(1, 10));
          for (int i = 0; i < NPTS_MAX; i++) degs[i] = TEMP_W'($urandom_range(0, 255));
        end
        default: begin
          secs[0] = PTIME_W'($urandom_range(0, 3));
          for (int i = 1; i < NPTS_MAX; i++)
            secs[i] = PTIME_W'(secs[i-1] + $urandom_range(1, 30));
          for (int i = 0; i < NPTS_MAX; i++) degs[i] = TEMP_W'($urandom_range(0, 255));
        end
      endcase
      // Temperature registers get random upper data bits, which the block must drop.
      for (int i = 0; i < NPTS_MAX; i++) begin
        write_reg(TIME_REG[i], secs[i]);
        write_reg(TEMP_REG[i], {CFG_DATA_W'($urandom_range(0, 255)) << TEMP_W} | degs[i]);
        pt_sec[i] = secs[i];
        pt_deg[i] = degs[i];
      end
      @(negedge clk_i);
      cfg_we_i = 1'b0;

      span = 2000;
      for (int i = 0; i < NUM_POINTS; i++)
        if (TIME_W'(pt_sec[i]) * MS_PER_SEC + 2000 > span)
          span = TIME_W'(pt_sec[i]) * MS_PER_SEC + 2000;

      quota = words_sent + ITEM_GOAL / NUM_PROFILES;
      while (words_sent < quota) begin
        if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
        if ($urandom_range(0, 9) < 7) begin
          // A curve run: usually a start, then ticks that mostly move forward in time,
          // some landing within 2 ms of a point, a few commands in between, and ticks past
          // the end so the finish and the return to idle are seen.
          origin   = $urandom();
          offset   = '0;
          ticks    = $urandom_range(3, 24);
          step_max = 2 * (span / ticks) + 1;
          if ($urandom_range(0, 9) != 0)
            send_word(KIND_START, VALUE_W'($urandom_range(0, 255)), origin, 1'b0, STATUS_OFF);
          for (int k = 0; k < ticks; k++) begin
            case ($urandom_range(0, 9))
              0, 1, 2: offset = TIME_W'(pt_sec[$urandom_range(0, NUM_POINTS - 1)]) * MS_PER_SEC
                                + $urandom_range(0, 4) - 2;
              3: send_word(KIND_W'($urandom_range(KIND_DISABLE, KIND_SET_PWM)), pick_value(),
                           origin + offset, 1'b0, STATUS_OFF);
              default: offset = offset + $urandom_range(0, step_max);
            endcase
            send_word(KIND_TICK, VALUE_W'($urandom_range(0, 255)), origin + offset, 1'b0,
                      STATUS_OFF);
          end
          offset = span + $urandom_range(0, 5000);
          send_word(KIND_TICK, '0, origin + offset, 1'b0, STATUS_OFF);
          send_word(KIND_TICK, '1, origin + offset + 100, 1'b0, STATUS_OFF);
        end else begin
          // Noise: any kind, reserved ones included, with any value and any time.
          repeat ($urandom_range(1, 6))
            send_word(KIND_W'($urandom_range(0, KIND_RSVD_LAST)), pick_value(), $urandom(),
                      1'b0, STATUS_OFF);
        end
        // Now and then hold the input until the block has answered everything.
        if ($urandom_range(0, 29) == 0) wait_for_results(0);
      end
    end

    wait_for_results(SETTLE_CYCLES);
    if (errors == 0 && status_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
